### sv/lbcc_pkg.sv
// Shared types, register indexes, mode codes and helpers for the LED blink and chase controller.
package lbcc_pkg;

   localparam int NUM_LEDS_DEF = 3;
   localparam int LED_COUNT    = 3;
   localparam int STEP_MS      = 1000;

   localparam int ELAPSED_W    = 16;
   localparam int DURATION_W   = 24;
   localparam int TIMING_W     = 32;
   localparam int HALF_W       = 16;
   localparam int MODE_W       = 2;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;

   // chase run timer is kept one bit past the duration and clamps there
   localparam int CHASE_EL_W   = DURATION_W + 1;
   localparam logic [CHASE_EL_W-1:0] CHASE_SAT = CHASE_EL_W'(1) << DURATION_W;

   localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CHASE  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_BAD    = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RETURN_MODE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CHASE_DURATION = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DEFAULT_LEVELS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BLUE_TIMING    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_GREEN_TIMING   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RED_TIMING     = 3'd6;

   typedef struct packed {
      logic [ELAPSED_W-1:0] elapsed_ms;
      logic                 restart;
   } req_type;

   typedef struct packed {
      logic [LED_COUNT-1:0] led_levels;
      logic [MODE_W-1:0]    active_mode;
   } rsp_type;

   // the unused mode code reads as none
   function automatic logic [MODE_W-1:0] fix_mode(input logic [MODE_W-1:0] m);
      fix_mode = (m == MODE_BAD) ? MODE_NONE : m;
   endfunction

endpackage

### sv/led_blink_and_chase_controller.sv
// A tick beat accepted on req passes through the input register and then the result register to rsp.
// Throughput: one tick per cycle while rsp is not stalled; all per-LED and chase updates are combinational.
// A full result register stalls the input register, which still takes a beat while it drains.
// Reset (synchronous, active high) clears the valid flags, configuration, timers and modes; chase lighting sets.
// Configuration writes are always accepted (csr_ready is tied high) and take effect on the next tick.
module led_blink_and_chase_controller #(
   parameter int NUM_LEDS = lbcc_pkg::NUM_LEDS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lbcc_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lbcc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lbcc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lbcc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CHASE_W = NUM_LEDS;
   localparam int IDX_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int LEDS    = lbcc_pkg::LED_COUNT;
   localparam int HW      = lbcc_pkg::HALF_W;
   localparam int EW      = lbcc_pkg::CHASE_EL_W;

   // pipeline registers
   logic                 req_valid_ff, req_valid_in;
   lbcc_pkg::req_type    req_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   lbcc_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   // configuration
   logic [lbcc_pkg::MODE_W-1:0]     return_mode_ff, return_mode_in;
   logic [lbcc_pkg::DURATION_W-1:0] duration_ff, duration_in;
   logic [LEDS-1:0]                 default_ff, default_in;
   logic [lbcc_pkg::TIMING_W-1:0]   timing_ff [LEDS];
   logic [lbcc_pkg::TIMING_W-1:0]   timing_in [LEDS];

   // blink state; a phase timer never passes its phase length, so 16 bits hold it
   logic [HW-1:0]   phase_ff [LEDS];
   logic [HW-1:0]   phase_in [LEDS];
   logic [LEDS-1:0] level_ff, level_in;
   logic [LEDS-1:0] started_ff, started_in;

   // chase state
   logic [EW-1:0]                   chase_el_ff, chase_el_in;
   logic [HW-1:0]                   step_el_ff, step_el_in;
   logic [IDX_W-1:0]                step_idx_ff, step_idx_in;
   logic                            lighting_ff, lighting_in;
   logic                            chase_started_ff, chase_started_in;
   logic [lbcc_pkg::MODE_W-1:0]     mode_ff, mode_in;
   logic [CHASE_W-1:0]              chase_lv_ff, chase_lv_in;

   logic out_free;
   logic do_step;
   logic req_accept;
   logic csr_write;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign do_step    = req_valid_ff && out_free;
   assign req_ready  = !req_valid_ff || out_free;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign req_valid_in = req_accept ? 1'b1 : (do_step ? 1'b0 : req_valid_ff);
   assign rsp_valid_in = do_step ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      logic [lbcc_pkg::ELAPSED_W-1:0] el;
      logic                           rst;
      logic [HW-1:0]                  on_t;
      logic [HW-1:0]                  off_t;
      logic [HW-1:0]                  len;
      logic [HW:0]                    psum;
      logic [HW:0]                    ssum;
      logic [EW:0]                    csum;
      logic                           adv;
      logic [CHASE_W-1:0]             step_mask;
      logic [7:0]                     chase_wide;
      logic [LEDS-1:0]                levels;
      logic [lbcc_pkg::MODE_W-1:0]    wmode;

      return_mode_in   = return_mode_ff;
      duration_in      = duration_ff;
      default_in       = default_ff;
      level_in         = level_ff;
      started_in       = started_ff;
      chase_el_in      = chase_el_ff;
      step_el_in       = step_el_ff;
      step_idx_in      = step_idx_ff;
      lighting_in      = lighting_ff;
      chase_started_in = chase_started_ff;
      mode_in          = mode_ff;
      chase_lv_in      = chase_lv_ff;
      for (int i = 0; i < LEDS; i++) begin
         timing_in[i] = timing_ff[i];
         phase_in[i]  = phase_ff[i];
      end

      el         = req_data_ff.elapsed_ms;
      rst        = req_data_ff.restart;
      on_t       = '0;
      off_t      = '0;
      len        = '0;
      psum       = '0;
      ssum       = '0;
      csum       = '0;
      adv        = 1'b0;
      step_mask  = '0;
      levels     = '0;
      chase_wide = '0;
      wmode      = lbcc_pkg::fix_mode(csr_wdata[lbcc_pkg::MODE_W-1:0]);

      if (csr_write) begin
         unique case (csr_index)
            lbcc_pkg::REG_PATTERN_MODE: begin
               mode_in = wmode;
               if (wmode == lbcc_pkg::MODE_SINGLE) begin
                  started_in = '0;
                  for (int i = 0; i < LEDS; i++) phase_in[i] = '0;
               end else if (wmode == lbcc_pkg::MODE_CHASE) begin
                  chase_el_in      = '0;
                  step_el_in       = '0;
                  step_idx_in      = '0;
                  lighting_in      = 1'b1;
                  chase_started_in = 1'b0;
                  chase_lv_in      = '0;
               end
            end
            lbcc_pkg::REG_RETURN_MODE: begin
               return_mode_in = wmode;
            end
            lbcc_pkg::REG_CHASE_DURATION: begin
               duration_in = csr_wdata[lbcc_pkg::DURATION_W-1:0];
            end
            lbcc_pkg::REG_DEFAULT_LEVELS: begin
               default_in = csr_wdata[LEDS-1:0];
               started_in = '0;
               for (int i = 0; i < LEDS; i++) phase_in[i] = '0;
            end
            lbcc_pkg::REG_BLUE_TIMING: begin
               timing_in[0]  = csr_wdata;
               started_in[0] = 1'b0;
               phase_in[0]   = '0;
            end
            lbcc_pkg::REG_GREEN_TIMING: begin
               timing_in[1]  = csr_wdata;
               started_in[1] = 1'b0;
               phase_in[1]   = '0;
            end
            lbcc_pkg::REG_RED_TIMING: begin
               timing_in[2]  = csr_wdata;
               started_in[2] = 1'b0;
               phase_in[2]   = '0;
            end
            default: begin
            end
         endcase
      end else if (do_step) begin
         if (rst) begin
            started_in = '0;
            for (int i = 0; i < LEDS; i++) phase_in[i] = '0;
            chase_el_in      = '0;
            step_el_in       = '0;
            step_idx_in      = '0;
            lighting_in      = 1'b1;
            chase_started_in = 1'b0;
            chase_lv_in      = '0;
         end

         if (mode_ff == lbcc_pkg::MODE_SINGLE) begin
            for (int i = 0; i < LEDS; i++) begin
               on_t  = timing_ff[i][lbcc_pkg::TIMING_W-1:HW];
               off_t = timing_ff[i][HW-1:0];
               if (on_t != '0) begin
                  if (off_t == '0) begin
                     levels[i] = 1'b1;
                  end else begin
                     if (!started_in[i]) begin
                        started_in[i] = 1'b1;
                        level_in[i]   = default_ff[i];
                        phase_in[i]   = '0;
                     end else begin
                        len  = level_in[i] ? on_t : off_t;
                        psum = {1'b0, phase_in[i]} + {1'b0, el};
                        if (psum > {1'b0, len}) begin
                           level_in[i] = !level_in[i];
                           phase_in[i] = '0;
                        end else begin
                           phase_in[i] = psum[HW-1:0];
                        end
                     end
                     levels[i] = level_in[i];
                  end
               end
            end
         end else if (mode_ff == lbcc_pkg::MODE_CHASE) begin
            if (!rst) begin
               csum = {1'b0, chase_el_in} + (EW+1)'(el);
               chase_el_in = (csum > {1'b0, lbcc_pkg::CHASE_SAT}) ?
                             lbcc_pkg::CHASE_SAT : csum[EW-1:0];
            end
            if (chase_el_in > {1'b0, duration_ff}) begin
               // expired: levels freeze, fall back to the return mode
               mode_in = return_mode_ff;
            end else if (!chase_started_in) begin
               chase_started_in = 1'b1;
               step_el_in       = '0;
               lighting_in      = 1'b1;
               adv              = 1'b1;
            end else begin
               ssum       = {1'b0, step_el_in} + {1'b0, el};
               step_el_in = ssum[HW] ? '1 : ssum[HW-1:0];
               if (step_el_in > HW'(lbcc_pkg::STEP_MS)) begin
                  step_el_in = '0;
                  adv        = 1'b1;
               end
            end
            if (adv) begin
               step_mask = CHASE_W'(1) << step_idx_in;
               if (lighting_in) chase_lv_in = chase_lv_in | step_mask;
               else             chase_lv_in = chase_lv_in & ~step_mask;
               if (step_idx_in == IDX_W'(NUM_LEDS - 1)) begin
                  step_idx_in = '0;
                  lighting_in = !lighting_in;
               end else begin
                  step_idx_in = step_idx_in + IDX_W'(1);
               end
            end
            chase_wide[CHASE_W-1:0] = chase_lv_in;
            levels = chase_wide[LEDS-1:0];
         end
      end

      rsp_data_in.led_levels  = levels;
      rsp_data_in.active_mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         return_mode_ff   <= lbcc_pkg::MODE_NONE;
         duration_ff      <= '0;
         default_ff       <= '0;
         level_ff         <= '0;
         started_ff       <= '0;
         chase_el_ff      <= '0;
         step_el_ff       <= '0;
         step_idx_ff      <= '0;
         lighting_ff      <= 1'b1;
         chase_started_ff <= 1'b0;
         mode_ff          <= lbcc_pkg::MODE_NONE;
         chase_lv_ff      <= '0;
         for (int i = 0; i < LEDS; i++) begin
            timing_ff[i] <= '0;
            phase_ff[i]  <= '0;
         end
      end else begin
         req_valid_ff     <= req_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         return_mode_ff   <= return_mode_in;
         duration_ff      <= duration_in;
         default_ff       <= default_in;
         level_ff         <= level_in;
         started_ff       <= started_in;
         chase_el_ff      <= chase_el_in;
         step_el_ff       <= step_el_in;
         step_idx_ff      <= step_idx_in;
         lighting_ff      <= lighting_in;
         chase_started_ff <= chase_started_in;
         mode_ff          <= mode_in;
         chase_lv_ff      <= chase_lv_in;
         for (int i = 0; i < LEDS; i++) begin
            timing_ff[i] <= timing_in[i];
            phase_ff[i]  <= phase_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) req_data_ff <= req_data;
      if (do_step)    rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   a_step_idx_bound: assert property (@(posedge clock) disable iff (reset)
      step_idx_ff <= IDX_W'(NUM_LEDS - 1))
      else $error("chase step index past last LED");

   a_chase_el_clamp: assert property (@(posedge clock) disable iff (reset)
      chase_el_ff <= lbcc_pkg::CHASE_SAT)
      else $error("chase run timer beyond clamp");

   a_step_to_result: assert property (@(posedge clock) disable iff (reset)
      do_step |=> rsp_valid_ff)
      else $error("tick beat left input register without a result");
`endif

endmodule
